// ===== hdl/iirl_pkg.sv =====
// ----------------------------------------------------------------------------
// iirl_pkg: shared definitions of the indexed insert/remove list
// Operation and status codes, cell command codes and the command word that
// the decoder broadcasts along the chain of entry cells.
// ----------------------------------------------------------------------------
package iirl_pkg;

  // Default sizes of the list.
  localparam int CAPACITY_DEF     = 64;
  localparam int HANDLE_WIDTH_DEF = 32;

  // Fixed widths of the channel fields.
  localparam int OP_W     = 3;
  localparam int INDEX_W  = 7;
  localparam int VALUE_W  = 32;
  localparam int ELEM_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Operation codes.
  localparam op_t OP_APPEND      = 3'd0;
  localparam op_t OP_SET         = 3'd1;
  localparam op_t OP_INSERT      = 3'd2;
  localparam op_t OP_REMOVE      = 3'd3;
  localparam op_t OP_REMOVE_LAST = 3'd4;
  localparam op_t OP_CLEAR       = 3'd5;
  localparam op_t OP_READ        = 3'd6;

  // Status codes.
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_INDEX = 2'd1;
  localparam status_t ST_FULL      = 2'd2;

  // Commands understood by every entry cell.
  typedef logic [2:0] cell_mode_t;
  localparam cell_mode_t CM_HOLD       = 3'd0;
  localparam cell_mode_t CM_WRITE      = 3'd1;
  localparam cell_mode_t CM_SHIFT_UP   = 3'd2;
  localparam cell_mode_t CM_SHIFT_DOWN = 3'd3;
  localparam cell_mode_t CM_CLEAR      = 3'd4;

  // Command word broadcast to the chain.
  typedef struct packed {
    cell_mode_t mode;  // what the cells do this cycle
    logic       pick;  // the target cell reports its entry
  } cell_cmd_t;

endpackage

// ===== hdl/iirl_cell.sv =====
// ----------------------------------------------------------------------------
// iirl_cell: one entry cell of the list chain
// Holds one handle, takes a written value or its neighbor's handle on a shift,
// goes to zero on a clear, and reports its handle when it is the target of a pick.
// ----------------------------------------------------------------------------
module iirl_cell #(
  parameter int POS    = 0,
  parameter int IDX_W  = 6,
  parameter int DATA_W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iirl_pkg::cell_cmd_t  cmd,
  input  logic [IDX_W-1:0]     tgt,
  input  logic [DATA_W-1:0]    wval,
  input  logic [DATA_W-1:0]    left_data,
  input  logic [DATA_W-1:0]    right_data,
  output logic [DATA_W-1:0]    data,
  output logic [DATA_W-1:0]    pick_data
);
  import iirl_pkg::*;

  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              is_tgt;
  logic              above_tgt;

  assign is_tgt    = (tgt == MY_POS);
  assign above_tgt = (MY_POS > tgt);

  // Next entry from the broadcast command and the two neighbors.
  always_comb begin
    data_nxt = data_r;
    case (cmd.mode)
      CM_WRITE: begin
        if (is_tgt) data_nxt = wval;
      end
      CM_SHIFT_UP: begin
        if (is_tgt) data_nxt = wval;
        else if (above_tgt) data_nxt = left_data;
      end
      CM_SHIFT_DOWN: begin
        if (is_tgt || above_tgt) data_nxt = right_data;
      end
      CM_CLEAR: data_nxt = '0;
      default: data_nxt = data_r;
    endcase
  end

  // The list resets to all zero entries.
  always_ff @(posedge clk) begin
    if (!rst_n) data_r <= '0;
    else data_r <= data_nxt;
  end

  assign data      = data_r;
  assign pick_data = (cmd.pick && is_tgt) ? data_r : '0;

endmodule

// ===== hdl/iirl_decode.sv =====
// ----------------------------------------------------------------------------
// iirl_decode: operation decoder of the list
// Checks the index against the count, forms the cell command, the target
// position, the value to write, the next count and the status.
// ----------------------------------------------------------------------------
module iirl_decode #(
  parameter int CAPACITY = 64,
  parameter int IDX_W    = 6,
  parameter int CNT_W    = 7,
  parameter int DATA_W   = 32
) (
  input  iirl_pkg::op_t        op,
  input  logic [6:0]           index,
  input  logic [DATA_W-1:0]    val,
  input  logic [CNT_W-1:0]     count,
  output iirl_pkg::cell_cmd_t  cmd,
  output logic [IDX_W-1:0]     tgt,
  output logic [DATA_W-1:0]    wval,
  output logic [CNT_W-1:0]     count_nxt,
  output iirl_pkg::status_t    status
);
  import iirl_pkg::*;

  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [CMP_W-1:0] CAP_X = CMP_W'(CAPACITY);

  logic [CMP_W-1:0] idx_x;
  logic [CMP_W-1:0] cnt_x;
  logic [CNT_W-1:0] cnt_dec;
  logic             full;

  assign idx_x   = CMP_W'(index);
  assign cnt_x   = CMP_W'(count);
  assign cnt_dec = count - CNT_W'(1);
  assign full    = (cnt_x >= CAP_X);

  // Per-operation decision; nothing changes unless the check passes.
  always_comb begin
    cmd.mode  = CM_HOLD;
    cmd.pick  = 1'b0;
    tgt       = idx_x[IDX_W-1:0];
    wval      = val;
    count_nxt = count;
    status    = ST_OK;
    case (op)
      OP_APPEND: begin
        tgt = count[IDX_W-1:0];
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.mode  = CM_WRITE;
          count_nxt = count + CNT_W'(1);
        end
      end
      OP_SET: begin
        if (idx_x >= cnt_x) status = ST_BAD_INDEX;
        else cmd.mode = CM_WRITE;
      end
      OP_INSERT: begin
        if (idx_x > cnt_x) begin
          status = ST_BAD_INDEX;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          cmd.mode  = CM_SHIFT_UP;
          count_nxt = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (idx_x >= cnt_x) begin
          status = ST_BAD_INDEX;
        end else begin
          cmd.mode  = CM_SHIFT_DOWN;
          cmd.pick  = 1'b1;
          count_nxt = cnt_dec;
        end
      end
      OP_REMOVE_LAST: begin
        tgt  = cnt_dec[IDX_W-1:0];
        wval = '0;
        if (count != '0) begin
          cmd.mode  = CM_WRITE;
          cmd.pick  = 1'b1;
          count_nxt = cnt_dec;
        end
      end
      OP_CLEAR: begin
        cmd.mode  = CM_CLEAR;
        count_nxt = '0;
      end
      OP_READ: begin
        if (idx_x >= cnt_x) status = ST_BAD_INDEX;
        else cmd.pick = 1'b1;
      end
      default: begin
        cmd.mode = CM_HOLD;
      end
    endcase
  end

endmodule

// ===== hdl/indexed_insert_remove_list.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_remove_list: ordered list of handles with fixed capacity
// A chain of entry cells that shifts every entry at once on insert and
// remove, with a decoder that broadcasts one command to all cells.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one operation word: in_op,
// in_index and in_value. The result channel (out_valid/out_ready) returns
// exactly one word per operation: out_element, out_count and out_status.
// Every operation finishes in the cycle in which it is accepted, because all
// cells of the chain update on the same edge; the result is held in the
// output register and shows on out_valid in the cycle after acceptance.
// If unstalled, throughput is one operation per cycle. The input is ready
// whenever the output register is empty or is being emptied in the same
// cycle, so a stalled receiver holds back new operations only while its
// word waits. Reset clears every entry to zero, sets the count to zero and
// empties the output register; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list #(
  parameter int CAPACITY     = iirl_pkg::CAPACITY_DEF,
  parameter int HANDLE_WIDTH = iirl_pkg::HANDLE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  iirl_pkg::op_t      in_op,
  input  logic [6:0]         in_index,
  input  logic [31:0]        in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_element,
  output logic [6:0]         out_count,
  output iirl_pkg::status_t  out_status
);
  import iirl_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int HW    = HANDLE_WIDTH;

  logic              accept;
  logic [HW+31:0]    value_x;
  logic [HW-1:0]     value_h;
  cell_cmd_t         dec_cmd;
  cell_cmd_t         cell_cmd;
  logic [IDX_W-1:0]  tgt;
  logic [HW-1:0]     wval;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  status_t           status;
  logic [HW-1:0]     cell_data [CAPACITY];
  logic [HW-1:0]     cell_pick [CAPACITY];
  logic [HW-1:0]     picked;
  logic [HW+31:0]    picked_x;
  logic [CNT_W+6:0]  count_x;

  logic              out_valid_r;
  logic [31:0]       element_r;
  logic [6:0]        out_count_r;
  status_t           status_r;

  // Handshake: a new word enters while the output register frees up.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Only the low handle bits of the value are kept.
  assign value_x = {{HW{1'b0}}, in_value};
  assign value_h = value_x[HW-1:0];

  iirl_decode #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W),
    .DATA_W   (HW)
  ) u_decode (
    .op        (in_op),
    .index     (in_index),
    .val       (value_h),
    .count     (count_r),
    .cmd       (dec_cmd),
    .tgt       (tgt),
    .wval      (wval),
    .count_nxt (count_nxt),
    .status    (status)
  );

  // The chain changes only on an accepted word.
  always_comb begin
    cell_cmd = dec_cmd;
    if (!accept) cell_cmd.mode = CM_HOLD;
  end

  // Row of entry cells, each linked to its two neighbors.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [HW-1:0] left_d;
    logic [HW-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    iirl_cell #(
      .POS    (g),
      .IDX_W  (IDX_W),
      .DATA_W (HW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cell_cmd),
      .tgt        (tgt),
      .wval       (wval),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .pick_data  (cell_pick[g])
    );
  end

  // At most one cell reports a handle; the others give zero.
  always_comb begin
    picked = '0;
    for (int k = 0; k < CAPACITY; k++) picked = picked | cell_pick[k];
  end

  assign picked_x = {32'b0, picked};
  assign count_x  = {7'b0, count_nxt};

  // Entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (accept) count_r <= count_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      element_r   <= picked_x[31:0];
      out_count_r <= count_x[6:0];
      status_r    <= status;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_element = element_r;
  assign out_count   = out_count_r;
  assign out_status  = status_r;

  // The count never goes beyond the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // A clear leaves an empty list.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_op == OP_CLEAR) |=> (count_r == '0))
    else $error("count not zero after clear");

  // A full status is only given when the list really is full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (status == ST_FULL) |=> (count_r == CNT_W'(CAPACITY)))
    else $error("full status on a list that is not full");

  // Refused operations return no handle.
  a_bad_no_elem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_OK) |-> (element_r == '0))
    else $error("handle returned with an error status");

endmodule
